// ===== hdl/seven_segment_serial_link_sender_top_macros.svh =====
// Assertion macros for the two-wire seven-segment link sender.
`ifndef SEVEN_SEGMENT_SERIAL_LINK_SENDER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_LINK_SENDER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SSSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sssl_pkg.sv =====
// Types, constants and the segment table of the two-wire seven-segment link sender.
package sssl_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int DIGIT_FIELDS  = 4;
    localparam int LOADED_DIGITS = (DIGIT_COUNT < DIGIT_FIELDS) ? DIGIT_COUNT : DIGIT_FIELDS;
    localparam int SLOTS         = 8;
    localparam int SLOT_W        = $clog2(SLOTS);

    localparam logic [7:0] CMD_DATA_ALL  = 8'h40;
    localparam logic [7:0] CMD_DATA_ONE  = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY   = 8'h88;

    localparam logic [1:0] FRAME_DATA_CMD = 2'd0;
    localparam logic [1:0] FRAME_ADDRESS  = 2'd1;
    localparam logic [1:0] FRAME_SEGMENTS = 2'd2;
    localparam logic [1:0] FRAME_DISPLAY  = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD_ALL = 2'd1,
        OP_LOAD_ONE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_ADDRESS    = 2'd1,
        REG_ACK_LIMIT  = 2'd2
    } t_reg_index;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ARMED    = 4'd1,
        PH_START_A  = 4'd2,
        PH_START_B  = 4'd3,
        PH_START_C  = 4'd4,
        PH_BIT_LOW  = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_ACK_PREP = 4'd7,
        PH_ACK_WAIT = 4'd8,
        PH_ACK_OK   = 4'd9,
        PH_STOP_A   = 4'd10,
        PH_STOP_B   = 4'd11,
        PH_STOP_C   = 4'd12
    } t_phase;

    typedef struct packed {
        logic [1:0]                   operation;
        logic [DIGIT_FIELDS-1:0][5:0] digits;
        logic [6:0]                   single_code;
        logic [1:0]                   position;
        logic                         data_line_in;
    } t_item;

    typedef struct packed {
        logic [2:0] brightness;
        logic [7:0] address_command;
        logic [7:0] ack_limit;
    } t_cfg;

    typedef struct packed {
        logic clock_line;
        logic data_line_out;
        logic data_drive;
        logic busy_res;
        logic last;
        logic ack_missing;
    } t_result;

    // Segment byte for a table code; codes past the table are blank.
    function automatic logic [7:0] seg_of(input logic [6:0] code);
        logic [7:0] seg;
        case (code)
            7'd0:  seg = 8'h3f;
            7'd1:  seg = 8'h06;
            7'd2:  seg = 8'h5b;
            7'd3:  seg = 8'h4f;
            7'd4:  seg = 8'h66;
            7'd5:  seg = 8'h6d;
            7'd6:  seg = 8'h7d;
            7'd7:  seg = 8'h07;
            7'd8:  seg = 8'h7f;
            7'd9:  seg = 8'h6f;
            7'd10: seg = 8'h77;
            7'd11: seg = 8'h7c;
            7'd12: seg = 8'h39;
            7'd13: seg = 8'h5e;
            7'd14: seg = 8'h79;
            7'd15: seg = 8'h71;
            7'd16: seg = 8'hbf;
            7'd17: seg = 8'h86;
            7'd18: seg = 8'hdb;
            7'd19: seg = 8'hcf;
            7'd20: seg = 8'he6;
            7'd21: seg = 8'hed;
            7'd22: seg = 8'hfd;
            7'd23: seg = 8'h87;
            7'd24: seg = 8'hff;
            7'd25: seg = 8'hef;
            7'd26: seg = 8'hf7;
            7'd27: seg = 8'hfc;
            7'd28: seg = 8'hb9;
            7'd29: seg = 8'hde;
            7'd30: seg = 8'hf9;
            7'd31: seg = 8'hf1;
            7'd32: seg = 8'h00;
            7'd33: seg = 8'h40;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== hdl/sssl_seg_enc.sv =====
// Digit code to segment byte encoder, with ASCII hex letters taken as 10 to 15.
module sssl_seg_enc (
    input  logic [6:0] i_code,
    output logic [7:0] o_segments
);
    import sssl_pkg::*;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_UPPER_F = 7'h46;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_F = 7'h66;
    localparam logic [6:0] HEX_TEN       = 7'd10;

    logic [6:0] code;

    always_comb begin
        if (i_code inside {[ASCII_UPPER_A:ASCII_UPPER_F]}) begin
            code = i_code - ASCII_UPPER_A + HEX_TEN;
        end else if (i_code inside {[ASCII_LOWER_A:ASCII_LOWER_F]}) begin
            code = i_code - ASCII_LOWER_A + HEX_TEN;
        end else begin
            code = i_code;
        end
    end

    assign o_segments = seg_of(code);

endmodule

// ===== hdl/sssl_seq.sv =====
// Link sequencer: segment buffer, frame and phase state, and one pin event per step.
module sssl_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  sssl_pkg::t_item   i_item,
    input  sssl_pkg::t_cfg    i_cfg,
    output sssl_pkg::t_result o_next_result
);
    import sssl_pkg::*;

    logic [DIGIT_FIELDS-1:0][7:0] seg_all;
    logic [7:0]                   seg_one;

    for (genvar g = 0; g < DIGIT_FIELDS; g++) begin : g_digit_enc
        sssl_seg_enc u_enc (
            .i_code     ({1'b0, i_item.digits[g]}),
            .o_segments (seg_all[g])
        );
    end

    sssl_seg_enc u_enc_single (
        .i_code     (i_item.single_code),
        .o_segments (seg_one)
    );

    logic [SLOTS-1:0][7:0] r_buf;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_frame, n_frame;
    logic [SLOT_W-1:0] r_byte_idx, n_byte_idx;
    logic [2:0]  r_bit_idx, n_bit_idx;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_ack_cnt, n_ack_cnt;
    logic        r_single, n_single;
    logic [1:0]  r_target, n_target;

    logic              wr_all;
    logic              wr_one;
    logic              do_begin;
    logic [1:0]        bb_frame;
    logic [SLOT_W-1:0] bb_idx;
    logic [7:0]        bb_byte;
    logic [7:0]        ack_base;
    logic [7:0]        ack_next;
    logic [SLOT_W:0]   idx_plus;
    logic              last;
    logic              miss;

    always_comb begin
        n_phase    = r_phase;
        n_frame    = r_frame;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_ack_cnt  = r_ack_cnt;
        n_single   = r_single;
        n_target   = r_target;
        wr_all     = 1'b0;
        wr_one     = 1'b0;
        do_begin   = 1'b0;
        bb_frame   = r_frame;
        bb_idx     = r_byte_idx;
        bb_byte    = 8'h00;
        last       = 1'b0;
        miss       = 1'b0;
        ack_base   = (r_phase == PH_ACK_PREP) ? 8'h00 : r_ack_cnt;
        ack_next   = ack_base + 8'd1;
        idx_plus   = {1'b0, r_byte_idx} + (SLOT_W+1)'(1);

        case (t_op'(i_item.operation))
            OP_LOAD_ALL, OP_LOAD_ONE: begin
                if (r_phase == PH_IDLE) begin
                    if (t_op'(i_item.operation) == OP_LOAD_ALL) begin
                        wr_all   = 1'b1;
                        n_single = 1'b0;
                    end else begin
                        wr_one   = 1'b1;
                        n_target = i_item.position;
                        n_single = 1'b1;
                    end
                    n_byte_idx = '0;
                    n_frame    = FRAME_DATA_CMD;
                    n_phase    = PH_ARMED;
                end
            end
            OP_TICK: begin
                case (r_phase)
                    PH_ARMED: begin
                        n_frame = FRAME_DATA_CMD;
                        n_phase = PH_START_A;
                    end
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: n_phase = PH_START_C;
                    PH_START_C: do_begin = 1'b1;
                    PH_BIT_LOW: n_phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_phase   = (r_bit_idx == 3'd7) ? PH_ACK_PREP : PH_BIT_LOW;
                    end
                    PH_ACK_PREP, PH_ACK_WAIT: begin
                        if (!i_item.data_line_in) begin
                            n_ack_cnt = ack_base;
                            n_phase   = PH_ACK_OK;
                        end else begin
                            n_ack_cnt = ack_next;
                            if (ack_next == i_cfg.ack_limit) begin
                                miss    = 1'b1;
                                n_phase = PH_ACK_OK;
                            end else begin
                                n_phase = PH_ACK_WAIT;
                            end
                        end
                    end
                    PH_ACK_OK: begin
                        if (r_frame == FRAME_ADDRESS) begin
                            n_byte_idx = '0;
                            do_begin   = 1'b1;
                            bb_frame   = FRAME_SEGMENTS;
                            bb_idx     = '0;
                        end else if (r_frame == FRAME_SEGMENTS && !r_single &&
                                     idx_plus < (SLOT_W+1)'(DIGIT_COUNT)) begin
                            n_byte_idx = idx_plus[SLOT_W-1:0];
                            do_begin   = 1'b1;
                            bb_frame   = FRAME_SEGMENTS;
                            bb_idx     = idx_plus[SLOT_W-1:0];
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    PH_STOP_A: n_phase = PH_STOP_B;
                    PH_STOP_B: begin
                        if (r_frame == FRAME_DISPLAY) begin
                            last    = 1'b1;
                            n_frame = FRAME_DATA_CMD;
                            n_phase = PH_IDLE;
                        end else begin
                            n_frame = (r_frame == FRAME_DATA_CMD) ? FRAME_ADDRESS
                                                                   : FRAME_DISPLAY;
                            n_phase = PH_STOP_C;
                        end
                    end
                    PH_STOP_C: n_phase = PH_START_A;
                    default: begin
                        n_frame = FRAME_DATA_CMD;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase

        // Start of a byte: pick it by frame and load the shifter.
        case (bb_frame)
            FRAME_DATA_CMD: bb_byte = r_single ? CMD_DATA_ONE : CMD_DATA_ALL;
            FRAME_ADDRESS:  bb_byte = r_single ? (CMD_ADDR_BASE | {6'd0, r_target})
                                               : i_cfg.address_command;
            FRAME_SEGMENTS: bb_byte = r_single ? r_buf[SLOT_W'(r_target)] : r_buf[bb_idx];
            default:        bb_byte = CMD_DISPLAY + {5'd0, i_cfg.brightness};
        endcase
        if (do_begin) begin
            n_shift   = bb_byte;
            n_bit_idx = 3'd0;
            n_frame   = bb_frame;
            n_phase   = PH_BIT_LOW;
        end

        // Pin levels follow the phase that the step lands in.
        o_next_result.clock_line    = 1'b1;
        o_next_result.data_line_out = 1'b1;
        o_next_result.data_drive    = 1'b1;
        case (n_phase)
            PH_START_B: begin
                o_next_result.data_line_out = 1'b0;
            end
            PH_START_C, PH_STOP_A: begin
                o_next_result.clock_line    = 1'b0;
                o_next_result.data_line_out = 1'b0;
            end
            PH_BIT_LOW: begin
                o_next_result.clock_line    = 1'b0;
                o_next_result.data_line_out = n_shift[0];
            end
            PH_BIT_HIGH: begin
                o_next_result.data_line_out = n_shift[0];
            end
            PH_ACK_PREP: begin
                o_next_result.clock_line = 1'b0;
            end
            PH_ACK_WAIT, PH_ACK_OK: begin
                o_next_result.data_drive = 1'b0;
            end
            PH_STOP_B: begin
                o_next_result.data_line_out = 1'b0;
            end
            default: ;
        endcase
        o_next_result.busy_res    = (n_phase != PH_IDLE) || last;
        o_next_result.last        = last;
        o_next_result.ack_missing = miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_frame    <= FRAME_DATA_CMD;
            r_byte_idx <= '0;
            r_bit_idx  <= 3'd0;
            r_shift    <= 8'h00;
            r_ack_cnt  <= 8'h00;
            r_single   <= 1'b0;
            r_target   <= 2'd0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_frame    <= n_frame;
            r_byte_idx <= n_byte_idx;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_ack_cnt  <= n_ack_cnt;
            r_single   <= n_single;
            r_target   <= n_target;
        end
    end

    // The segment buffer holds no reset value; slots are defined once loaded.
    always_ff @(posedge i_clk) begin
        if (i_advance && wr_all) begin
            for (int i = 0; i < LOADED_DIGITS; i++) begin
                r_buf[SLOT_W'(i)] <= seg_all[i];
            end
        end
        if (i_advance && wr_one) begin
            r_buf[SLOT_W'(i_item.position)] <= seg_one;
        end
    end

endmodule

// ===== hdl/seven_segment_serial_link_sender_top.sv =====
// Top level of the two-wire seven-segment link sender with its handshake registers.
//
// This block drives the clock and data pins of a two-wire link to a four-digit
// seven-segment controller, one pin event per tick item. A load item (all four
// digit codes, or one code with its position) fills the segment buffer and arms
// a sequence; the following tick items walk through the data-mode command, the
// address command with the segment bytes, and the display control command with
// the brightness, each frame being start, bytes sent LSB first with an
// acknowledge wait after each, and stop. A missing acknowledge is flagged on
// ack_missing and the sequence goes on. Loads that arrive while a sequence is
// running are ignored and simply report the current pin levels. Every input
// item yields exactly one result. The block takes one item per clock cycle while
// results are taken: a transfer on the input lands in an input register, the
// combinational sequencer step turns it into the next pin event, and the event
// sits in a result register. While a result is stalled, one more item can still
// be taken into an empty input register; after that the input stalls until the
// result is taken. The configuration registers are written through a plain write
// port and should only be changed while no sequence is in progress. No clearing
// pass follows reset.
module seven_segment_serial_link_sender_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_operation,
    input  logic [5:0] i_digit_zero,
    input  logic [5:0] i_digit_one,
    input  logic [5:0] i_digit_two,
    input  logic [5:0] i_digit_three,
    input  logic [6:0] i_single_code,
    input  logic [1:0] i_position,
    input  logic       i_data_line_in,
    // Result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_clock_line,
    output logic       o_data_line_out,
    output logic       o_data_drive,
    output logic       o_busy_res,
    output logic       o_last,
    output logic       o_ack_missing,
    // Configuration port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import sssl_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result next_result;
    t_cfg    r_cfg;
    logic    advance;

    // The sequencer steps whenever an item is held and the result register is
    // free or being emptied in this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.operation    <= i_operation;
            r_item.digits[0]    <= i_digit_zero;
            r_item.digits[1]    <= i_digit_one;
            r_item.digits[2]    <= i_digit_two;
            r_item.digits[3]    <= i_digit_three;
            r_item.single_code  <= i_single_code;
            r_item.position     <= i_position;
            r_item.data_line_in <= i_data_line_in;
        end
        if (advance) begin
            r_result <= next_result;
        end
    end

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness      <= 3'd2;
            r_cfg.address_command <= CMD_ADDR_BASE;
            r_cfg.ack_limit       <= 8'd200;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_BRIGHTNESS: r_cfg.brightness      <= i_cfg_data[2:0];
                REG_ADDRESS:    r_cfg.address_command <= i_cfg_data;
                REG_ACK_LIMIT:  r_cfg.ack_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sssl_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_item        (r_item),
        .i_cfg         (r_cfg),
        .o_next_result (next_result)
    );

    assign o_valid         = r_out_valid;
    assign o_clock_line    = r_result.clock_line;
    assign o_data_line_out = r_result.data_line_out;
    assign o_data_drive    = r_result.data_drive;
    assign o_busy_res      = r_result.busy_res;
    assign o_last          = r_result.last;
    assign o_ack_missing   = r_result.ack_missing;

`include "seven_segment_serial_link_sender_top_macros.svh"

    // The final event of a sequence leaves both lines high and driven.
    `SSSL_ASSERT_NOW(a_last_idle_lines, o_valid && o_last,
        o_busy_res && o_clock_line && o_data_line_out && o_data_drive,
        "last event without idle line levels")
    // A released data line always reads high.
    `SSSL_ASSERT_NOW(a_release_high, o_valid && !o_data_drive,
        o_data_line_out && o_clock_line, "released data line not reported high")
    // A missed acknowledge is only reported while the line is released.
    `SSSL_ASSERT_NOW(a_miss_released, o_valid && o_ack_missing,
        !o_data_drive && o_busy_res, "acknowledge miss outside the acknowledge wait")
    // A sequencer step always leaves a result waiting.
    `SSSL_ASSERT_NEXT(a_step_result, advance, o_valid, "sequencer step produced no result")

endmodule
